// ----- rtl/acs_pkg.sv -----
package acs_pkg;

	localparam int unsigned KindW   = 3;
	localparam int unsigned ModeW   = 3;
	localparam int unsigned HourW   = 5;
	localparam int unsigned MinuteW = 6;
	localparam int unsigned SecondW = 6;

	localparam logic [HourW-1:0]   HourMax          = 5'd23;
	localparam logic [MinuteW-1:0] MinuteMax        = 6'd59;
	localparam logic [HourW-1:0]   AlarmHourReset   = 5'd6;
	localparam logic [MinuteW-1:0] AlarmMinuteReset = 6'd30;
	localparam logic [SecondW-1:0] BuzzSecondLimit  = 6'd2;

	typedef enum logic [KindW-1:0] {
		KIND_TIME  = 3'd0,
		KIND_COMBO = 3'd1,
		KIND_SET   = 3'd2,
		KIND_UP    = 3'd3,
		KIND_DOWN  = 3'd4
	} kind_t;

	typedef enum logic [ModeW-1:0] {
		MODE_SHOW       = 3'd0,
		MODE_ALM_HOUR   = 3'd1,
		MODE_ALM_MINUTE = 3'd2,
		MODE_CLK_HOUR   = 3'd3,
		MODE_CLK_MINUTE = 3'd4
	} mode_t;

	typedef struct packed {
		mode_t               mode;
		logic [HourW-1:0]    wake_hour;
		logic [MinuteW-1:0]  wake_minute;
		logic [HourW-1:0]    held_hour;
		logic [MinuteW-1:0]  held_minute;
		logic [SecondW-1:0]  held_second;
	} acs_state_t;

	typedef struct packed {
		logic [KindW-1:0]    kind;
		logic [SecondW-1:0]  rtc_second;
		logic [MinuteW-1:0]  rtc_minute;
		logic [HourW-1:0]    rtc_hour;
	} acs_item_t;

	typedef struct packed {
		logic [ModeW-1:0]    current_mode;
		logic [HourW-1:0]    alarm_hour_out;
		logic [MinuteW-1:0]  alarm_minute_out;
		logic [HourW-1:0]    shown_hour;
		logic [MinuteW-1:0]  shown_minute;
		logic                buzzer_on;
		logic                clock_write;
		logic [SecondW-1:0]  write_second;
	} acs_result_t;

	function automatic logic [HourW-1:0] hour_up(input logic [HourW-1:0] v);
		logic [HourW:0] n;
		n = {1'b0, v} + {{HourW{1'b0}}, 1'b1};
		return (n > {1'b0, HourMax}) ? '0 : n[HourW-1:0];
	endfunction

	function automatic logic [HourW-1:0] hour_down(input logic [HourW-1:0] v);
		return (v == '0) ? HourMax : v - {{(HourW-1){1'b0}}, 1'b1};
	endfunction

	function automatic logic [MinuteW-1:0] minute_up(input logic [MinuteW-1:0] v);
		logic [MinuteW:0] n;
		n = {1'b0, v} + {{MinuteW{1'b0}}, 1'b1};
		return (n > {1'b0, MinuteMax}) ? '0 : n[MinuteW-1:0];
	endfunction

	function automatic logic [MinuteW-1:0] minute_down(input logic [MinuteW-1:0] v);
		return (v == '0) ? MinuteMax : v - {{(MinuteW-1){1'b0}}, 1'b1};
	endfunction

endpackage

// ----- rtl/acs_step.sv -----
module acs_step
	import acs_pkg::*;
(
	input  acs_state_t  cur,
	input  acs_item_t   item,
	input  logic        alarm_enable,
	output acs_state_t  nxt,
	output acs_result_t res
);

	logic               wr;
	logic [SecondW-1:0] wsec;
	logic               up;
	logic               buzz;

	assign up = (item.kind == KIND_UP);

	always_comb begin
		nxt  = cur;
		wr   = 1'b0;
		wsec = '0;
		case (item.kind)
			KIND_TIME: begin
				if (cur.mode == MODE_SHOW || cur.mode == MODE_CLK_HOUR ||
				    cur.mode == MODE_CLK_MINUTE) begin
					nxt.held_second = item.rtc_second;
					nxt.held_minute = item.rtc_minute;
					nxt.held_hour   = item.rtc_hour;
				end
			end
			KIND_COMBO: begin
				if (cur.mode == MODE_SHOW || cur.mode == MODE_ALM_HOUR ||
				    cur.mode == MODE_ALM_MINUTE) begin
					nxt.mode = MODE_CLK_HOUR;
				end
			end
			KIND_SET: begin
				unique case (cur.mode)
					MODE_SHOW:       nxt.mode = MODE_ALM_HOUR;
					MODE_ALM_HOUR:   nxt.mode = MODE_ALM_MINUTE;
					MODE_ALM_MINUTE: nxt.mode = MODE_SHOW;
					MODE_CLK_HOUR:   nxt.mode = MODE_CLK_MINUTE;
					MODE_CLK_MINUTE: nxt.mode = MODE_SHOW;
					default:         nxt.mode = cur.mode;
				endcase
			end
			KIND_UP, KIND_DOWN: begin
				unique case (cur.mode)
					MODE_ALM_HOUR:
						nxt.wake_hour = up ? hour_up(cur.wake_hour)
						                   : hour_down(cur.wake_hour);
					MODE_ALM_MINUTE:
						nxt.wake_minute = up ? minute_up(cur.wake_minute)
						                     : minute_down(cur.wake_minute);
					MODE_CLK_HOUR: begin
						nxt.held_hour = up ? hour_up(cur.held_hour)
						                   : hour_down(cur.held_hour);
						wr   = 1'b1;
						wsec = cur.held_second;
					end
					MODE_CLK_MINUTE: begin
						// minute edit restarts the chip at second zero
						nxt.held_minute = up ? minute_up(cur.held_minute)
						                     : minute_down(cur.held_minute);
						wr   = 1'b1;
						wsec = '0;
					end
					default: begin
					end
				endcase
			end
			default: begin
			end
		endcase
	end

	assign buzz = (nxt.mode == MODE_SHOW) && alarm_enable &&
	              (nxt.held_hour == nxt.wake_hour) &&
	              (nxt.held_minute == nxt.wake_minute) &&
	              (nxt.held_second < BuzzSecondLimit);

	always_comb begin
		res.current_mode     = nxt.mode;
		res.alarm_hour_out   = nxt.wake_hour;
		res.alarm_minute_out = nxt.wake_minute;
		res.shown_hour       = nxt.held_hour;
		res.shown_minute     = nxt.held_minute;
		res.buzzer_on        = buzz;
		res.clock_write      = wr;
		res.write_second     = wsec;
	end

endmodule

// ----- rtl/alarm_clock_set_controller_unit.sv -----
// Alarm clock set controller.
// Input channel (in_valid/in_ready) carries one event word: kind plus the
// time read from the clock chip. Output channel (out_valid/out_ready) returns
// one result word per event: mode, alarm time, held time, buzzer and a clock
// write request with the seconds to write.
// Configuration channel (cfg_valid/cfg_ready/cfg_data) writes alarm_enable;
// cfg_ready is always high. Write it only while the block is idle.
// An accepted event passes through the input register, then the result
// register, before it is presented on the output. One event per cycle
// while the receiver does not stall; the step logic is combinational.
// When the receiver stalls, the result register holds, the input register
// still takes one more word, and in_ready drops only when both are full.
// Reset (arst_n low): mode show, alarm 06:30, held time 00:00:00,
// alarm_enable set, both channels empty.
module alarm_clock_set_controller_unit
	import acs_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic               cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [KindW-1:0]   kind,
	input  logic [SecondW-1:0] rtc_second,
	input  logic [MinuteW-1:0] rtc_minute,
	input  logic [HourW-1:0]   rtc_hour,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [ModeW-1:0]   current_mode,
	output logic [HourW-1:0]   alarm_hour_out,
	output logic [MinuteW-1:0] alarm_minute_out,
	output logic [HourW-1:0]   shown_hour,
	output logic [MinuteW-1:0] shown_minute,
	output logic               buzzer_on,
	output logic               clock_write,
	output logic [SecondW-1:0] write_second
);

	logic        alarm_enable_q;
	acs_state_t  state_q;
	acs_state_t  state_nxt;
	acs_item_t   item_s1;
	logic        valid_s1;
	acs_result_t res_nxt;
	acs_result_t res_s2;
	logic        valid_s2;
	logic        advance;

	assign cfg_ready = 1'b1;
	assign advance   = !valid_s2 || out_ready;
	assign in_ready  = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alarm_enable_q <= 1'b1;
		end else if (cfg_valid) begin
			alarm_enable_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= '{kind: kind, rtc_second: rtc_second,
			             rtc_minute: rtc_minute, rtc_hour: rtc_hour};
		end
	end

	acs_step u_step (
		.cur          (state_q),
		.item         (item_s1),
		.alarm_enable (alarm_enable_q),
		.nxt          (state_nxt),
		.res          (res_nxt)
	);

	// commit the state only when the word moves into the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{mode: MODE_SHOW, wake_hour: AlarmHourReset,
			             wake_minute: AlarmMinuteReset, held_hour: '0,
			             held_minute: '0, held_second: '0};
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
			if (valid_s1) begin
				state_q <= state_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			res_s2 <= res_nxt;
		end
	end

	assign out_valid        = valid_s2;
	assign current_mode     = res_s2.current_mode;
	assign alarm_hour_out   = res_s2.alarm_hour_out;
	assign alarm_minute_out = res_s2.alarm_minute_out;
	assign shown_hour       = res_s2.shown_hour;
	assign shown_minute     = res_s2.shown_minute;
	assign buzzer_on        = res_s2.buzzer_on;
	assign clock_write      = res_s2.clock_write;
	assign write_second     = res_s2.write_second;

	a_write_mode: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && clock_write |->
			(current_mode == MODE_CLK_HOUR || current_mode == MODE_CLK_MINUTE))
		else $error("clock write outside clock set modes");

	a_no_write_sec: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !clock_write |-> write_second == '0)
		else $error("write_second nonzero without clock write");

	a_buzz_match: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && buzzer_on |->
			(current_mode == MODE_SHOW && shown_hour == alarm_hour_out &&
			 shown_minute == alarm_minute_out))
		else $error("buzzer on without alarm match in show mode");

	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !valid_s2 |=> out_valid)
		else $error("pending word not moved to output");

endmodule

// ----- verif/testbench.sv -----
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import acs_pkg::*;

	localparam int unsigned CycleLimit = 1_000_000;
	localparam int unsigned PhaseEvents = 500;

	logic               clk;
	logic               arst_n;
	logic               cfg_valid;
	logic               cfg_ready;
	logic               cfg_data;
	logic               in_valid;
	logic               in_ready;
	logic [KindW-1:0]   kind;
	logic [SecondW-1:0] rtc_second;
	logic [MinuteW-1:0] rtc_minute;
	logic [HourW-1:0]   rtc_hour;
	logic               out_valid;
	logic               out_ready;
	logic [ModeW-1:0]   current_mode;
	logic [HourW-1:0]   alarm_hour_out;
	logic [MinuteW-1:0] alarm_minute_out;
	logic [HourW-1:0]   shown_hour;
	logic [MinuteW-1:0] shown_minute;
	logic               buzzer_on;
	logic               clock_write;
	logic [SecondW-1:0] write_second;

	// predicted state of the controller
	bit                 alarm_en;
	mode_t              mode_q;
	logic [HourW-1:0]   alarm_hour_q;
	logic [MinuteW-1:0] alarm_minute_q;
	logic [HourW-1:0]   held_hour_q;
	logic [MinuteW-1:0] held_minute_q;
	logic [SecondW-1:0] held_second_q;

	acs_result_t expected_readouts[$];

	bit          tx_gaps;
	bit          rx_stalls;
	int unsigned rx_hold;
	int unsigned cycle_count;
	int unsigned mismatches;
	int unsigned events_sent;
	int unsigned noise_sent;
	int unsigned words_checked;
	int unsigned writes_seen;
	int unsigned buzzes_seen;

	alarm_clock_set_controller_unit u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.kind            (kind),
		.rtc_second      (rtc_second),
		.rtc_minute      (rtc_minute),
		.rtc_hour        (rtc_hour),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.current_mode    (current_mode),
		.alarm_hour_out  (alarm_hour_out),
		.alarm_minute_out(alarm_minute_out),
		.shown_hour      (shown_hour),
		.shown_minute    (shown_minute),
		.buzzer_on       (buzzer_on),
		.clock_write     (clock_write),
		.write_second    (write_second)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic int unsigned wrap_step(int unsigned v, int unsigned top, bit up);
		if (up)
			return (v + 1 > top) ? 0 : v + 1;
		return (v == 0) ? top : v - 1;
	endfunction

	// apply one event to the predicted state and return the readout it causes
	function automatic acs_result_t apply_event(logic [KindW-1:0] k, logic [SecondW-1:0] s,
			logic [MinuteW-1:0] m, logic [HourW-1:0] h);
		acs_result_t r;
		bit up;
		r = '0;
		up = (k == KIND_UP);
		case (k)
		KIND_TIME: begin
			if (mode_q != MODE_ALM_HOUR && mode_q != MODE_ALM_MINUTE) begin
				held_second_q = s;
				held_minute_q = m;
				held_hour_q = h;
			end
		end
		KIND_COMBO: begin
			if (mode_q < MODE_CLK_HOUR)
				mode_q = MODE_CLK_HOUR;
		end
		KIND_SET: begin
			case (mode_q)
			MODE_SHOW:       mode_q = MODE_ALM_HOUR;
			MODE_ALM_HOUR:   mode_q = MODE_ALM_MINUTE;
			MODE_ALM_MINUTE: mode_q = MODE_SHOW;
			MODE_CLK_HOUR:   mode_q = MODE_CLK_MINUTE;
			MODE_CLK_MINUTE: mode_q = MODE_SHOW;
			default: ;
			endcase
		end
		KIND_UP, KIND_DOWN: begin
			case (mode_q)
			MODE_ALM_HOUR:
				alarm_hour_q = HourW'(wrap_step(32'(alarm_hour_q), 32'(HourMax), up));
			MODE_ALM_MINUTE:
				alarm_minute_q = MinuteW'(wrap_step(32'(alarm_minute_q),
					32'(MinuteMax), up));
			MODE_CLK_HOUR: begin
				held_hour_q = HourW'(wrap_step(32'(held_hour_q), 32'(HourMax), up));
				r.clock_write = 1'b1;
				r.write_second = held_second_q;
			end
			MODE_CLK_MINUTE: begin
				held_minute_q = MinuteW'(wrap_step(32'(held_minute_q), 32'(MinuteMax), up));
				r.clock_write = 1'b1;
			end
			default: ;
			endcase
		end
		default: ;
		endcase
		r.current_mode = mode_q;
		r.alarm_hour_out = alarm_hour_q;
		r.alarm_minute_out = alarm_minute_q;
		r.shown_hour = held_hour_q;
		r.shown_minute = held_minute_q;
		r.buzzer_on = (mode_q == MODE_SHOW) && alarm_en && (held_hour_q == alarm_hour_q) &&
			(held_minute_q == alarm_minute_q) && (held_second_q < BuzzSecondLimit);
		return r;
	endfunction

	function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endfunction

	// send one event word; the prediction is made at the accepting edge
	task automatic send_event(logic [KindW-1:0] k, logic [SecondW-1:0] s,
			logic [MinuteW-1:0] m, logic [HourW-1:0] h);
		int unsigned gap;
		gap = tx_gaps ? pick_gap() : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		rtc_second <= s;
		rtc_minute <= m;
		rtc_hour <= h;
		do
			@(posedge clk);
		while (!in_ready);
		expected_readouts.push_back(apply_event(k, s, m, h));
		if (k > KIND_DOWN)
			noise_sent++;
		else
			events_sent++;
	endtask

	task automatic send_key(logic [KindW-1:0] k);
		send_event(k, SecondW'($urandom), MinuteW'($urandom), HourW'($urandom));
	endtask

	// hold the input side until every pending readout has been checked
	task automatic go_idle();
		in_valid <= 1'b0;
		while (expected_readouts.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_alarm_enable(bit en);
		go_idle();
		cfg_valid <= 1'b1;
		cfg_data <= en;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		alarm_en = en;
	endtask

	task automatic test_show_mode();
		send_event({KindW{1'b1}}, '1, '1, '1);
		send_event(KIND_TIME, '0, AlarmMinuteReset, AlarmHourReset);
		send_event(KIND_TIME, 6'd1, AlarmMinuteReset, AlarmHourReset);
		send_event(KIND_TIME, BuzzSecondLimit, AlarmMinuteReset, AlarmHourReset);
		send_key(KIND_UP);
		send_key(KIND_DOWN);
		send_key(KindW'(KIND_DOWN + 1));
		send_event(KIND_TIME, '1, '1, '1);
		send_event(KIND_TIME, MinuteMax, MinuteMax, HourMax);
	endtask

	task automatic test_alarm_setting();
		send_key(KIND_SET);
		send_key(KIND_DOWN);
		send_key(KIND_UP);
		send_key(KIND_SET);
		send_key(KIND_UP);
		send_event(KIND_TIME, '0, '0, '0);
		send_key(KIND_SET);
		send_key(KIND_SET);
		send_key(KIND_COMBO);
	endtask

	task automatic test_clock_setting();
		send_key(KIND_UP);
		send_key(KIND_COMBO);
		send_event(KIND_TIME, '1, '1, '1);
		send_key(KIND_DOWN);
		send_key(KIND_SET);
		send_key(KIND_UP);
		send_key(KIND_DOWN);
		send_key(KIND_SET);
	endtask

	task automatic test_alarm_enable();
		write_alarm_enable(1'b0);
		send_event(KIND_TIME, '0, alarm_minute_q, alarm_hour_q);
		write_alarm_enable(1'b1);
		send_event(KIND_TIME, 6'd1, alarm_minute_q, alarm_hour_q);
	endtask

	task automatic run_random_phase(int unsigned goal);
		int unsigned r;
		int unsigned len;
		logic [KindW-1:0] dir;
		goal += events_sent;
		while (events_sent < goal) begin
			r = $urandom_range(0, 99);
			if (r < 15) begin
				send_event(KIND_TIME, SecondW'($urandom_range(0, 3)), alarm_minute_q,
					alarm_hour_q);
			end else if (r < 25) begin
				send_event(KIND_TIME, SecondW'($urandom_range(0, MinuteMax)),
					MinuteW'($urandom_range(0, MinuteMax)),
					HourW'($urandom_range(0, HourMax)));
			end else if (r < 30) begin
				send_event(KIND_TIME, SecondW'($urandom), MinuteW'($urandom),
					HourW'($urandom));
			end else if (r < 38) begin
				send_key(KIND_COMBO);
			end else if (r < 55) begin
				send_key(KIND_SET);
			end else if (r < 77) begin
				send_key($urandom_range(0, 1) ? KIND_UP : KIND_DOWN);
			end else if (r < 95) begin
				// long runs in one direction reach the wrap points
				len = $urandom_range(2, 30);
				dir = $urandom_range(0, 1) ? KIND_UP : KIND_DOWN;
				repeat (len) send_key(dir);
			end else begin
				send_key(KindW'($urandom_range(KIND_DOWN + 1, {KindW{1'b1}})));
			end
			if ($urandom_range(0, 199) == 0)
				go_idle();
		end
	endtask

	task automatic test_random_traffic();
		write_alarm_enable(1'b1);
		tx_gaps = 1'b1;
		rx_stalls = 1'b1;
		run_random_phase(PhaseEvents);
		write_alarm_enable(1'b0);
		tx_gaps = 1'b0;
		rx_stalls = 1'b0;
		run_random_phase(PhaseEvents);
		write_alarm_enable(1'b1);
		tx_gaps = 1'b0;
		rx_stalls = 1'b1;
		run_random_phase(PhaseEvents);
		write_alarm_enable(1'($urandom_range(0, 1)));
		tx_gaps = 1'b1;
		rx_stalls = 1'b0;
		run_random_phase(PhaseEvents);
	endtask

	// receiver back-pressure
	always @(posedge clk) begin
		if (!rx_stalls) begin
			out_ready <= 1'b1;
		end else if (rx_hold > 0) begin
			out_ready <= 1'b0;
			rx_hold--;
		end else begin
			rx_hold = pick_gap();
			if (rx_hold > 0) begin
				out_ready <= 1'b0;
				rx_hold--;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		acs_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_readouts.size() == 0) begin
				$error("result word with no event pending");
				mismatches++;
			end else begin
				want = expected_readouts.pop_front();
				check_field("current_mode", 8'(want.current_mode), 8'(current_mode));
				check_field("alarm_hour_out", 8'(want.alarm_hour_out), 8'(alarm_hour_out));
				check_field("alarm_minute_out", 8'(want.alarm_minute_out),
					8'(alarm_minute_out));
				check_field("shown_hour", 8'(want.shown_hour), 8'(shown_hour));
				check_field("shown_minute", 8'(want.shown_minute), 8'(shown_minute));
				check_field("buzzer_on", 8'(want.buzzer_on), 8'(buzzer_on));
				check_field("clock_write", 8'(want.clock_write), 8'(clock_write));
				check_field("write_second", 8'(want.write_second), 8'(write_second));
				words_checked++;
				writes_seen += want.clock_write;
				buzzes_seen += want.buzzer_on;
			end
		end
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CycleLimit) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles, %0d words pending", cycle_count,
			expected_readouts.size());
		$display("simulation failed");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = 1'b0;
		in_valid = 1'b0;
		kind = '0;
		rtc_second = '0;
		rtc_minute = '0;
		rtc_hour = '0;
		out_ready = 1'b0;
		tx_gaps = 1'b1;
		rx_stalls = 1'b1;
		rx_hold = 0;
		alarm_en = 1'b1;
		mode_q = MODE_SHOW;
		alarm_hour_q = AlarmHourReset;
		alarm_minute_q = AlarmMinuteReset;
		held_hour_q = '0;
		held_minute_q = '0;
		held_second_q = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_show_mode();
		test_alarm_setting();
		test_clock_setting();
		test_alarm_enable();
		test_random_traffic();
		go_idle();
		$display("%0d key and time events plus %0d unused kinds, %0d result words checked",
			events_sent, noise_sent, words_checked);
		$display("%0d clock writes and %0d buzzer words seen, alarm enable set both ways",
			writes_seen, buzzes_seen);
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
